// File: design/aos_pkg.sv
package aos_pkg;

	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 32;

	localparam logic [CfgIdxW-1:0] REG_RANGE_LOW       = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_RANGE_HIGH      = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_RAW_GAIN        = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_RAW_OFFSET      = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_SIGNAL_GAIN     = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_SIGNAL_OFFSET   = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_FIXED_OUT_VALUE = 3'd6;
	localparam logic [CfgIdxW-1:0] REG_OUTPUT_FORMAT   = 3'd7;

	localparam logic signed [31:0] RST_RANGE_LOW       = 32'sd0;
	localparam logic signed [31:0] RST_RANGE_HIGH      = 32'sd6553600;
	localparam logic signed [31:0] RST_RAW_GAIN        = 32'sd65536;
	localparam logic signed [31:0] RST_RAW_OFFSET      = 32'sd0;
	localparam logic signed [31:0] RST_SIGNAL_GAIN     = 32'sd65536;
	localparam logic signed [31:0] RST_SIGNAL_OFFSET   = 32'sd0;
	localparam logic signed [31:0] RST_FIXED_OUT_VALUE = 32'sd0;
	localparam logic [3:0]         RST_OUTPUT_FORMAT   = 4'd1;

	localparam int unsigned FMT_SIGNED_BIT = 2;
	localparam int unsigned FMT_BE_BIT     = 3;

	localparam logic [1:0] NB_ONE   = 2'd0;
	localparam logic [1:0] NB_TWO   = 2'd1;
	localparam logic [1:0] NB_THREE = 2'd2;
	localparam logic [1:0] NB_FOUR  = 2'd3;

	typedef struct packed {
		logic               enable;
		logic               fixed_out_request;
		logic               test_on;
		logic signed [31:0] test_value;
		logic signed [31:0] process_value;
	} in_item_t;

	typedef struct packed {
		logic [31:0]        raw_word;
		logic [2:0]         byte_count;
		logic               saturated;
		logic signed [31:0] signal_value;
	} out_item_t;

endpackage

// File: design/analog_output_scaler_unit.sv
// An accepted transaction passes through item_s1, v_s2, prod_*_s3, t_*_s4 and
// raw_s5/sig_s5 before its result is loaded into the output register out_q.
// Throughput: one transaction per cycle; set by the six-register pipeline that
// advances whenever the output register is empty or being taken.
// Transactions with enable low are accepted and produce no result.
// Reset (arst_n low, asynchronous): pipeline emptied, configuration registers
// return to their default values.
module analog_output_scaler_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [aos_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [aos_pkg::CfgDataW-1:0]  cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  aos_pkg::in_item_t             in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output aos_pkg::out_item_t            out_data
);
	import aos_pkg::*;

	logic signed [31:0] range_low_q, range_high_q, raw_gain_q, raw_offset_q;
	logic signed [31:0] signal_gain_q, signal_offset_q, fixed_out_value_q;
	logic [3:0]         output_format_q;

	logic adv;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, out_valid_q;

	in_item_t           item_s1;
	logic signed [31:0] v_s2;
	logic signed [63:0] prod_raw_s3, prod_sig_s3;
	logic signed [63:0] t_raw_s4, t_sig_s4;
	logic signed [31:0] raw_s5;
	logic signed [47:0] sig_s5;
	out_item_t          out_q;

	logic signed [31:0] sel_v, clamp_v;
	logic signed [63:0] raw_off_ext, sig_off_ext, raw_sum, sig_sum;
	logic signed [33:0] raw_ext, max_v, min_v, raw_sat;
	logic               sat_flag;
	logic [31:0]        bits, word;
	logic signed [31:0] sig_sat;
	logic [1:0]         nb;

	assign adv       = !out_valid_q || out_ready;
	assign in_ready  = adv;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q       <= RST_RANGE_LOW;
			range_high_q      <= RST_RANGE_HIGH;
			raw_gain_q        <= RST_RAW_GAIN;
			raw_offset_q      <= RST_RAW_OFFSET;
			signal_gain_q     <= RST_SIGNAL_GAIN;
			signal_offset_q   <= RST_SIGNAL_OFFSET;
			fixed_out_value_q <= RST_FIXED_OUT_VALUE;
			output_format_q   <= RST_OUTPUT_FORMAT;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_RANGE_LOW:       range_low_q       <= cfg_data;
				REG_RANGE_HIGH:      range_high_q      <= cfg_data;
				REG_RAW_GAIN:        raw_gain_q        <= cfg_data;
				REG_RAW_OFFSET:      raw_offset_q      <= cfg_data;
				REG_SIGNAL_GAIN:     signal_gain_q     <= cfg_data;
				REG_SIGNAL_OFFSET:   signal_offset_q   <= cfg_data;
				REG_FIXED_OUT_VALUE: fixed_out_value_q <= cfg_data;
				REG_OUTPUT_FORMAT:   output_format_q   <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			vld_s4      <= 1'b0;
			vld_s5      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			// drop disabled transactions at the input
			vld_s1      <= in_valid && in_data.enable;
			vld_s2      <= vld_s1;
			vld_s3      <= vld_s2;
			vld_s4      <= vld_s3;
			vld_s5      <= vld_s4;
			out_valid_q <= vld_s5;
		end
	end

	always_comb begin
		priority if (item_s1.fixed_out_request) begin
			sel_v = fixed_out_value_q;
		end else if (item_s1.test_on) begin
			sel_v = item_s1.test_value;
		end else begin
			sel_v = item_s1.process_value;
		end
		priority if (sel_v > range_high_q) begin
			clamp_v = range_high_q;
		end else if (sel_v < range_low_q) begin
			clamp_v = range_low_q;
		end else begin
			clamp_v = sel_v;
		end
	end

	assign raw_off_ext = {{16{raw_offset_q[31]}}, raw_offset_q, 16'b0};
	assign sig_off_ext = {{16{signal_offset_q[31]}}, signal_offset_q, 16'b0};

	// round half away from zero: negative values take one less than half
	assign raw_sum = t_raw_s4 + (t_raw_s4[63] ? 64'sh7FFF_FFFF : 64'sh8000_0000);
	assign sig_sum = t_sig_s4 + (t_sig_s4[63] ? 64'sh0000_7FFF : 64'sh0000_8000);

	always_comb begin
		nb      = output_format_q[1:0];
		raw_ext = {{2{raw_s5[31]}}, raw_s5};
		if (output_format_q[FMT_SIGNED_BIT]) begin
			unique case (nb)
				NB_ONE:   begin max_v = 34'sh7F;       min_v = -34'sh80;       end
				NB_TWO:   begin max_v = 34'sh7FFF;     min_v = -34'sh8000;     end
				NB_THREE: begin max_v = 34'sh7F_FFFF;  min_v = -34'sh80_0000;  end
				NB_FOUR:  begin max_v = 34'sh7FFF_FFFF; min_v = -34'sh8000_0000; end
				default:  begin max_v = 34'sh7FFF_FFFF; min_v = -34'sh8000_0000; end
			endcase
		end else begin
			min_v = 34'sh0;
			unique case (nb)
				NB_ONE:   max_v = 34'shFF;
				NB_TWO:   max_v = 34'shFFFF;
				NB_THREE: max_v = 34'shFF_FFFF;
				NB_FOUR:  max_v = 34'shFFFF_FFFF;
				default:  max_v = 34'shFFFF_FFFF;
			endcase
		end
		priority if (raw_ext > max_v) begin
			raw_sat  = max_v;
			sat_flag = 1'b1;
		end else if (raw_ext < min_v) begin
			raw_sat  = min_v;
			sat_flag = 1'b1;
		end else begin
			raw_sat  = raw_ext;
			sat_flag = 1'b0;
		end
		bits = raw_sat[31:0];
		unique case ({output_format_q[FMT_BE_BIT], nb})
			{1'b0, NB_ONE}:   word = {24'b0, bits[7:0]};
			{1'b0, NB_TWO}:   word = {16'b0, bits[15:0]};
			{1'b0, NB_THREE}: word = {8'b0, bits[23:0]};
			{1'b0, NB_FOUR}:  word = bits;
			{1'b1, NB_ONE}:   word = {24'b0, bits[7:0]};
			{1'b1, NB_TWO}:   word = {16'b0, bits[7:0], bits[15:8]};
			{1'b1, NB_THREE}: word = {8'b0, bits[7:0], bits[15:8], bits[23:16]};
			{1'b1, NB_FOUR}:  word = {bits[7:0], bits[15:8], bits[23:16], bits[31:24]};
			default:          word = bits;
		endcase
		priority if (sig_s5 > 48'sh0000_7FFF_FFFF) begin
			sig_sat = 32'sh7FFF_FFFF;
		end else if (sig_s5 < -48'sh0000_8000_0000) begin
			sig_sat = 32'sh8000_0000;
		end else begin
			sig_sat = sig_s5[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1     <= in_data;
			v_s2        <= clamp_v;
			prod_raw_s3 <= raw_gain_q * v_s2;
			prod_sig_s3 <= signal_gain_q * v_s2;
			t_raw_s4    <= prod_raw_s3 + raw_off_ext;
			t_sig_s4    <= prod_sig_s3 + sig_off_ext;
			raw_s5      <= raw_sum[63:32];
			sig_s5      <= sig_sum[63:16];
			out_q.raw_word     <= word;
			out_q.byte_count   <= {1'b0, nb} + 3'd1;
			out_q.saturated    <= sat_flag;
			out_q.signal_value <= sig_sat;
		end
	end

endmodule

// File: design/aos_chk.sv
module aos_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input aos_pkg::out_item_t out_data
);
	import aos_pkg::*;

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed or dropped");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while output register empty");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.byte_count != 3'd0 && out_data.byte_count <= 3'd4)
		else $error("byte count out of range");

	a_unused_bytes_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.byte_count == 3'd1 || out_data.byte_count == 3'd2)
		|-> out_data.raw_word[31:16] == 16'b0)
		else $error("bytes beyond byte count not zero");

endmodule

bind analog_output_scaler_unit aos_chk u_aos_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
